/* rtl/core/bfeu_pkg.sv */
// ----------------------------------------------------------------------------
// bfeu_pkg
// Shared types and constants for the Brainfuck execution unit.
// ----------------------------------------------------------------------------
package bfeu_pkg;

  // Cell store geometry
  localparam int CELL_COUNT = 65536;
  localparam int CELL_AW    = $clog2(CELL_COUNT);
  localparam logic [CELL_AW:0] CELL_COUNT_W = (CELL_AW + 1)'(CELL_COUNT);

  // Program index widths (fixed by the instruction fields)
  localparam int PROGRAM_DEPTH = 4096;
  localparam int PIDX_W        = $clog2(PROGRAM_DEPTH);
  localparam int NIDX_W        = PIDX_W + 1;

  localparam int BYTE_W = 8;
  localparam int AMT_W  = 8;

  // Instruction codes
  typedef enum logic [2:0] {
    CMD_RIGHT = 3'd0,
    CMD_LEFT  = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_SUB   = 3'd3,
    CMD_OUT   = 3'd4,
    CMD_READ  = 3'd5,
    CMD_OPEN  = 3'd6,
    CMD_CLOSE = 3'd7
  } cmd_t;

  // Cell store read request
  typedef struct packed {
    logic               en;
    logic [CELL_AW-1:0] addr;
  } cell_rd_req_t;

  // Cell store write request
  typedef struct packed {
    logic               en;
    logic [CELL_AW-1:0] addr;
    logic [BYTE_W-1:0]  data;
  } cell_wr_req_t;

endpackage

/* rtl/core/bfeu_in_if.sv */
// ----------------------------------------------------------------------------
// bfeu_in_if
// Instruction request channel: valid/ready handshake plus instruction fields.
// ----------------------------------------------------------------------------
interface bfeu_in_if import bfeu_pkg::*; ();

  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [AMT_W-1:0]  amount;
  logic [PIDX_W-1:0] jump_target;
  logic [PIDX_W-1:0] current_index;
  logic [BYTE_W-1:0] input_byte;

  modport source (
    output valid, command, amount, jump_target, current_index, input_byte,
    input  ready
  );

  modport sink (
    input  valid, command, amount, jump_target, current_index, input_byte,
    output ready
  );

endinterface

/* rtl/core/bfeu_out_if.sv */
// ----------------------------------------------------------------------------
// bfeu_out_if
// Result request channel: valid/ready handshake plus result fields.
// ----------------------------------------------------------------------------
interface bfeu_out_if import bfeu_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [NIDX_W-1:0] next_index;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic [AMT_W-1:0]  out_repeat;

  modport source (
    output valid, next_index, out_valid, out_byte, out_repeat,
    input  ready
  );

  modport sink (
    input  valid, next_index, out_valid, out_byte, out_repeat,
    output ready
  );

endinterface

/* rtl/core/brainfuck_execution_unit_top.sv */
// ----------------------------------------------------------------------------
// brainfuck_execution_unit_top
// Executes one run-length-compressed Brainfuck instruction per request and
// returns the next instruction index and any output byte.
// ----------------------------------------------------------------------------
//
//   channel   modport  fields
//   in_ch     sink     command, amount, jump_target, current_index, input_byte
//   out_ch    source   next_index, out_valid, out_byte, out_repeat
//
// One instruction per cycle sustained while results are not stalled. From
// accept to result: cell read, then execute and write back, then output
// register. Back-to-back accesses to the same cell are covered by write
// forwarding in the cell store. After reset a clearing sweep zeroes all 65536
// cells, one per cycle; no request is taken until it ends. A stalled result
// holds the execute stage, which in turn holds off new requests.
module brainfuck_execution_unit_top import bfeu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bfeu_in_if.sink    in_ch,
  bfeu_out_if.source out_ch
);

  logic               store_busy;
  logic [BYTE_W-1:0]  cell_rd;
  cell_rd_req_t       rd_req;
  cell_wr_req_t       wr_req;

  logic [CELL_AW-1:0] dp_r, dp_nxt;

  // Execute stage
  logic               s1_v_r;
  cmd_t               s1_cmd_r;
  logic [AMT_W-1:0]   s1_amt_r;
  logic [PIDX_W-1:0]  s1_tgt_r;
  logic [PIDX_W-1:0]  s1_cur_r;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic [CELL_AW-1:0] s1_addr_r;

  // Output register
  logic               o_v_r;
  logic [NIDX_W-1:0]  o_next_r, o_next_nxt;
  logic               o_emit_r, o_emit_nxt;
  logic [BYTE_W-1:0]  o_byte_r, o_byte_nxt;
  logic [AMT_W-1:0]   o_rep_r, o_rep_nxt;

  logic               s1_adv;
  logic               in_fire;
  logic [CELL_AW:0]   ptr_sum;
  logic [CELL_AW:0]   amt_ext;

  // Handshake
  assign s1_adv      = s1_v_r && (!o_v_r || out_ch.ready);
  assign in_ch.ready = !store_busy && (!s1_v_r || s1_adv);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Data pointer move, wrapping at the cell count
  assign amt_ext = (CELL_AW + 1)'(in_ch.amount);

  always_comb begin
    ptr_sum = {1'b0, dp_r};
    dp_nxt  = dp_r;
    case (in_ch.command)
      CMD_RIGHT: begin
        ptr_sum = {1'b0, dp_r} + amt_ext;
        if (ptr_sum >= CELL_COUNT_W) begin
          ptr_sum = ptr_sum - CELL_COUNT_W;
        end
        dp_nxt = ptr_sum[CELL_AW-1:0];
      end
      CMD_LEFT: begin
        if ({1'b0, dp_r} >= amt_ext) begin
          ptr_sum = {1'b0, dp_r} - amt_ext;
        end else begin
          ptr_sum = {1'b0, dp_r} + CELL_COUNT_W - amt_ext;
        end
        dp_nxt = ptr_sum[CELL_AW-1:0];
      end
      default: dp_nxt = dp_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r <= '0;
    end else if (in_fire) begin
      dp_r <= dp_nxt;
    end
  end

  // Cell read for the accepted instruction, at the pointer it sees
  assign rd_req.en   = in_fire;
  assign rd_req.addr = dp_r;

  // Execute stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_ch.command;
      s1_amt_r  <= in_ch.amount;
      s1_tgt_r  <= in_ch.jump_target;
      s1_cur_r  <= in_ch.current_index;
      s1_byte_r <= in_ch.input_byte;
      s1_addr_r <= dp_r;
    end
  end

  // Execute: cell update and next index
  always_comb begin
    wr_req.en   = 1'b0;
    wr_req.addr = s1_addr_r;
    wr_req.data = cell_rd;
    o_next_nxt  = NIDX_W'(s1_cur_r) + 1'b1;
    o_emit_nxt  = 1'b0;
    o_byte_nxt  = '0;
    o_rep_nxt   = '0;
    case (s1_cmd_r)
      CMD_RIGHT, CMD_LEFT: begin
        wr_req.en = 1'b0;
      end
      CMD_ADD: begin
        wr_req.en   = s1_adv;
        wr_req.data = cell_rd + s1_amt_r;
      end
      CMD_SUB: begin
        wr_req.en   = s1_adv;
        wr_req.data = cell_rd - s1_amt_r;
      end
      CMD_OUT: begin
        if (s1_amt_r != '0) begin
          o_emit_nxt = 1'b1;
          o_byte_nxt = cell_rd;
          o_rep_nxt  = s1_amt_r;
        end
      end
      CMD_READ: begin
        wr_req.en   = s1_adv;
        wr_req.data = s1_byte_r;
      end
      CMD_OPEN: begin
        if (cell_rd == '0) begin
          o_next_nxt = NIDX_W'(s1_tgt_r) + 1'b1;
        end
      end
      CMD_CLOSE: begin
        if (cell_rd != '0) begin
          o_next_nxt = NIDX_W'(s1_tgt_r) + 1'b1;
        end
      end
      default: wr_req.en = 1'b0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (s1_adv) begin
      o_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_next_r <= o_next_nxt;
      o_emit_r <= o_emit_nxt;
      o_byte_r <= o_byte_nxt;
      o_rep_r  <= o_rep_nxt;
    end
  end

  assign out_ch.valid      = o_v_r;
  assign out_ch.next_index = o_next_r;
  assign out_ch.out_valid  = o_emit_r;
  assign out_ch.out_byte   = o_byte_r;
  assign out_ch.out_repeat = o_rep_r;

  bfeu_cell_store u_cell_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (cell_rd),
    .busy    (store_busy)
  );

endmodule

/* rtl/core/bfeu_cell_store.sv */
// ----------------------------------------------------------------------------
// bfeu_cell_store
// Byte cell memory with registered read, write-to-read forwarding and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module bfeu_cell_store import bfeu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_rd_req_t      rd_req,
  input  cell_wr_req_t      wr_req,
  output logic [BYTE_W-1:0] rd_data,
  output logic              busy
);

  logic [BYTE_W-1:0]  mem [CELL_COUNT];
  logic [BYTE_W-1:0]  rd_data_r;
  logic               fwd_r;
  logic [BYTE_W-1:0]  fwd_data_r;
  logic               clearing_r;
  logic [CELL_AW-1:0] clr_addr_r;

  logic               mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [BYTE_W-1:0]  mem_wdata;

  // Clearing sweep owns the write port until every cell is zero
  always_comb begin
    if (clearing_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_req.en;
      mem_waddr = wr_req.addr;
      mem_wdata = wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == CELL_AW'(CELL_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Memory read port; a write to the same cell in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data_r  <= mem[rd_req.addr];
      fwd_data_r <= wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_req.en) begin
      fwd_r <= wr_req.en && (wr_req.addr == rd_req.addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_data_r;
  assign busy    = clearing_r;

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for brainfuck_execution_unit_top. Instruction requests
// come from a queue of directed and random items. Each accepted request is
// run through a cycle-free model of the data pointer and the cell store. Every
// result request is checked field by field against the oldest prediction.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bfeu_pkg::*;

  // One instruction as the host fetches it
  typedef struct {
    cmd_t              command;
    logic [AMT_W-1:0]  amount;
    logic [PIDX_W-1:0] target;
    logic [PIDX_W-1:0] index;
    logic [BYTE_W-1:0] in_byte;
  } instr_t;

  // What the unit returns for one instruction
  typedef struct {
    logic [NIDX_W-1:0] next_index;
    logic              emit;
    logic [BYTE_W-1:0] data_byte;
    logic [AMT_W-1:0]  emit_count;
  } exec_result_t;

  localparam int RANDOM_ITEMS = 1900;
  localparam int MAX_SHOWN    = 10;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst_n;

  bfeu_in_if  in_ch ();
  bfeu_out_if out_ch ();

  brainfuck_execution_unit_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Model state: data pointer and cell store
  logic [BYTE_W-1:0]  cell_mem [0:CELL_COUNT-1];
  logic [CELL_AW-1:0] data_ptr;

  instr_t       instr_queue[$];
  exec_result_t predicted_results[$];

  int     mismatches;
  bit     in_fire;
  bit     quiet;
  int     in_gap;
  int     out_stall;
  instr_t drive_item;

  always #5 clk = ~clk;

  // Gap length: mostly none or short, a few long, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Execute one instruction on the model state
  function automatic exec_result_t execute_instr(instr_t ins);
    exec_result_t res;
    logic [BYTE_W-1:0] cell_val;
    cell_val       = cell_mem[data_ptr];
    res.next_index = NIDX_W'(ins.index) + 1'b1;
    res.emit       = 1'b0;
    res.data_byte  = '0;
    res.emit_count = '0;
    case (ins.command)
      CMD_RIGHT: data_ptr = data_ptr + CELL_AW'(ins.amount);
      CMD_LEFT:  data_ptr = data_ptr - CELL_AW'(ins.amount);
      CMD_ADD:   cell_mem[data_ptr] = cell_val + ins.amount;
      CMD_SUB:   cell_mem[data_ptr] = cell_val - ins.amount;
      CMD_OUT: begin
        if (ins.amount != '0) begin
          res.emit       = 1'b1;
          res.data_byte  = cell_val;
          res.emit_count = ins.amount;
        end
      end
      CMD_READ:  cell_mem[data_ptr] = ins.in_byte;
      CMD_OPEN: begin
        if (cell_val == '0) res.next_index = NIDX_W'(ins.target) + 1'b1;
      end
      default: begin
        if (cell_val != '0) res.next_index = NIDX_W'(ins.target) + 1'b1;
      end
    endcase
    return res;
  endfunction

  task automatic add_instr(cmd_t c, int amt, int tgt, int idx, int b);
    instr_t ins;
    ins.command = c;
    ins.amount  = AMT_W'(amt);
    ins.target  = PIDX_W'(tgt);
    ins.index   = PIDX_W'(idx);
    ins.in_byte = BYTE_W'(b);
    instr_queue.push_back(ins);
  endtask

  // Random instruction: small moves keep the pointer on cells already touched
  task automatic add_random_instr();
    instr_t ins;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)      ins.command = CMD_RIGHT;
    else if (r < 30) ins.command = CMD_LEFT;
    else if (r < 45) ins.command = CMD_ADD;
    else if (r < 57) ins.command = CMD_SUB;
    else if (r < 67) ins.command = CMD_OUT;
    else if (r < 75) ins.command = CMD_READ;
    else if (r < 88) ins.command = CMD_OPEN;
    else             ins.command = CMD_CLOSE;
    if (ins.command == CMD_RIGHT || ins.command == CMD_LEFT)
      ins.amount = ($urandom_range(0, 99) < 85) ? AMT_W'($urandom_range(0, 3))
                                                : AMT_W'($urandom_range(0, 255));
    else if (ins.command == CMD_OUT && $urandom_range(0, 9) == 0)
      ins.amount = '0;
    else
      ins.amount = AMT_W'($urandom_range(0, 255));
    ins.target  = ($urandom_range(0, 19) == 0) ? '1 : PIDX_W'($urandom_range(0, 4095));
    ins.index   = ($urandom_range(0, 19) == 0) ? '1 : PIDX_W'($urandom_range(0, 4095));
    ins.in_byte = ($urandom_range(0, 9) == 0) ? '1 : BYTE_W'($urandom_range(0, 255));
    instr_queue.push_back(ins);
  endtask

  task automatic report(string field, int exp_val, int act_val);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch on %s at %0t: expected %0d, got %0d",
               field, $realtime, exp_val, act_val);
  endtask

  // Instruction driver: changes on the falling edge
  always @(negedge clk) begin
    if (in_ch.valid && !in_fire) begin
      // hold the request until it is taken
    end else if (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_gap--;
    end else if (instr_queue.size() > 0) begin
      drive_item = instr_queue.pop_front();
      in_ch.command       <= drive_item.command;
      in_ch.amount        <= drive_item.amount;
      in_ch.jump_target   <= drive_item.target;
      in_ch.current_index <= drive_item.index;
      in_ch.input_byte    <= drive_item.in_byte;
      in_ch.valid         <= 1'b1;
      in_gap = pick_gap();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
    end
  end

  // Monitor: check results first, then predict the request taken this edge
  always @(posedge clk) begin
    exec_result_t exp_res;
    instr_t       taken;
    in_fire = 1'b0;
    if (rst_n) begin
      if ($urandom_range(0, 299) == 0) quiet = !quiet;

      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          report("unexpected result", 0, 1);
        end else begin
          exp_res = predicted_results.pop_front();
          if (out_ch.next_index !== exp_res.next_index)
            report("next_index", exp_res.next_index, out_ch.next_index);
          if (out_ch.out_valid !== exp_res.emit)
            report("out_valid", exp_res.emit, out_ch.out_valid);
          if (out_ch.out_byte !== exp_res.data_byte)
            report("out_byte", exp_res.data_byte, out_ch.out_byte);
          if (out_ch.out_repeat !== exp_res.emit_count)
            report("out_repeat", exp_res.emit_count, out_ch.out_repeat);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        in_fire             = 1'b1;
        taken.command       = in_ch.command;
        taken.amount        = in_ch.amount;
        taken.target        = in_ch.jump_target;
        taken.index         = in_ch.current_index;
        taken.in_byte       = in_ch.input_byte;
        predicted_results.push_back(execute_instr(taken));
      end
    end
  end

  // Run limit, sized for the clearing sweep plus worst-case idling
  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Main sequence
  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_RIGHT;
    in_ch.amount        = '0;
    in_ch.jump_target   = '0;
    in_ch.current_index = '0;
    in_ch.input_byte    = '0;
    out_ch.ready        = 1'b0;
    mismatches          = 0;
    in_fire             = 1'b0;
    quiet               = 1'b0;
    in_gap              = 0;
    out_stall           = 0;
    data_ptr            = '0;
    for (int i = 0; i < CELL_COUNT; i++) cell_mem[i] = '0;

    // Directed part: field extremes, every command, wrap and branch cases
    add_instr(CMD_READ,  0,   0,    0,    255);  // end-of-input byte
    add_instr(CMD_OUT,   255, 0,    1,    0);    // widest emit
    add_instr(CMD_ADD,   1,   0,    2,    0);    // 255 + 1 wraps to zero
    add_instr(CMD_OPEN,  0,   4095, 10,   0);    // zero cell jumps past target
    add_instr(CMD_CLOSE, 0,   7,    4095, 0);    // zero cell falls through to end
    add_instr(CMD_SUB,   1,   0,    3,    0);    // 0 - 1 wraps to 255
    add_instr(CMD_OPEN,  0,   100,  4,    0);    // nonzero cell falls through
    add_instr(CMD_CLOSE, 0,   0,    5,    0);    // nonzero cell jumps back
    add_instr(CMD_CLOSE, 0,   4095, 6,    0);
    add_instr(CMD_OUT,   0,   0,    7,    0);    // empty emit
    add_instr(CMD_LEFT,  1,   0,    8,    0);    // pointer wraps below zero
    add_instr(CMD_READ,  0,   0,    9,    165);
    add_instr(CMD_OUT,   1,   0,    10,   0);
    add_instr(CMD_RIGHT, 1,   0,    11,   0);    // pointer wraps back to zero
    add_instr(CMD_OUT,   3,   0,    12,   0);
    add_instr(CMD_RIGHT, 255, 0,    13,   0);
    add_instr(CMD_ADD,   255, 0,    14,   0);
    add_instr(CMD_SUB,   0,   0,    15,   0);
    add_instr(CMD_OUT,   128, 0,    16,   0);
    add_instr(CMD_LEFT,  255, 0,    17,   0);
    add_instr(CMD_RIGHT, 0,   0,    18,   0);
    add_instr(CMD_LEFT,  0,   0,    19,   0);
    add_instr(CMD_READ,  0,   2730, 1365, 0);
    add_instr(CMD_OPEN,  255, 1365, 2730, 170);
    add_instr(CMD_OUT,   85,  0,    4095, 0);

    // Random part
    for (int i = 0; i < RANDOM_ITEMS; i++) add_random_instr();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: everything sent, every prediction matched
    while (instr_queue.size() != 0 || in_ch.valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
